// ===== rtl/core/i2c_crc_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C CRC word reader package
// Word types of the tick and result channels, command and status codes,
// CRC-8 constants and default timing values shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_crc_pkg;

  // Command codes carried in the opcode field.
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ      = 3'd3;
  localparam logic [2:0] OP_READ_WORD = 3'd4;

  // Completion status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NACK    = 2'd1;
  localparam logic [1:0] STATUS_CRC     = 2'd2;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

  // CRC-8 with polynomial x^8+x^5+x^4+1, processed MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Default bus timing, in ticks.
  localparam int STRETCH_WAIT_TICKS_DEF = 1000;
  localparam int HOLD_TICKS_DEF         = 10;
  localparam int GAP_TICKS_DEF          = 20;
  localparam int HIGH_TICKS_DEF         = 5;

  // One tick word: optional command plus sampled pin levels.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic [7:0] stretch_limit;
    logic       sda_sample;
    logic       scl_sample;
  } tick_t;

  // One result word: pin drives and command status for the tick.
  typedef struct packed {
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_crc_word_reader_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master with CRC-8 word read
// Open-drain bus sequencer for start, stop, byte write, byte read and a
// CRC-checked word read, advanced by one tick word per cycle when the result side does not stall.
// ----------------------------------------------------------------------------
// Each accepted word is one microsecond tick of the bus sequencer. The block
// takes one tick word every cycle while the result side does not stall, and
// returns exactly one result word for it; a result passes through the input
// register and then the result register. The rate of one word per cycle, when
// not stalled, is set by the combinational update of the sequencer state,
// which also settles up to three chained zero-length steps (end of a byte,
// zero gap, command completion) inside that same cycle. A stalled result
// register holds the input register, which takes a new word as soon as its current word moves on.
`default_nettype none

module i2c_master_crc_word_reader_unit
  import i2c_crc_pkg::*;
#(
  parameter int STRETCH_WAIT_TICKS = STRETCH_WAIT_TICKS_DEF,
  parameter int HOLD_TICKS         = HOLD_TICKS_DEF,
  parameter int GAP_TICKS          = GAP_TICKS_DEF,
  parameter int HIGH_TICKS         = HIGH_TICKS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire tick_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam logic [9:0] STRETCH_CNT = 10'(STRETCH_WAIT_TICKS);
  localparam logic [9:0] HOLD_CNT    = 10'(HOLD_TICKS);
  localparam logic [9:0] GAP_CNT     = 10'(GAP_TICKS);
  localparam logic [9:0] HIGH_CNT    = 10'(HIGH_TICKS);
  localparam logic [9:0] SAMPLE_CNT  = 10'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3, PH_P0, PH_P1, PH_P2, PH_P3,
    PH_WB, PH_WH, PH_WL, PH_WA, PH_WS, PH_RC, PH_RS, PH_RP, PH_RA,
    PH_RH, PH_RE, PH_RB, PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  tick_count;
    logic [3:0]  bit_index;
    logic [1:0]  byte_index;
    logic [2:0]  command_kind;
    logic [7:0]  shift_byte;
    logic [15:0] word_data;
    logic [7:0]  crc_value;
    logic [7:0]  stretch_left;
    logic        final_ack;
    logic [1:0]  error_code;
    logic        scl_pull;
    logic        sda_pull;
    logic [7:0]  limit_q;
  } seq_t;

  localparam seq_t SEQ_RESET = '{
    phase: PH_IDLE, tick_count: 10'd0, bit_index: 4'd0, byte_index: 2'd0,
    command_kind: 3'd0, shift_byte: 8'd0, word_data: 16'd0,
    crc_value: CRC_INIT, stretch_left: 8'd0, final_ack: 1'b0,
    error_code: STATUS_OK, scl_pull: 1'b0, sda_pull: 1'b0, limit_q: 8'd0
  };

  // CRC-8 update over one byte, MSB first.
  function automatic logic [7:0] crc_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // One sequencer step, taken when the tick count has run out.
  function automatic seq_t advance(seq_t s, logic sda_in, logic scl_in);
    seq_t       r;
    logic [3:0] bit_next;
    r = s;
    bit_next = s.bit_index + 4'd1;
    case (s.phase)
      PH_S0: begin r.sda_pull = 1'b0; r.tick_count = 10'd1; r.phase = PH_S1; end
      PH_S1: begin r.scl_pull = 1'b0; r.tick_count = 10'd1; r.phase = PH_S2; end
      PH_S2: begin r.sda_pull = 1'b1; r.tick_count = HOLD_CNT; r.phase = PH_S3; end
      PH_S3: begin r.scl_pull = 1'b1; r.tick_count = HOLD_CNT; r.phase = PH_DONE; end
      PH_P0: begin r.scl_pull = 1'b1; r.tick_count = 10'd1; r.phase = PH_P1; end
      PH_P1: begin r.sda_pull = 1'b1; r.tick_count = 10'd1; r.phase = PH_P2; end
      PH_P2: begin r.scl_pull = 1'b0; r.tick_count = HOLD_CNT; r.phase = PH_P3; end
      PH_P3: begin r.sda_pull = 1'b0; r.tick_count = HOLD_CNT; r.phase = PH_DONE; end
      PH_WB: begin
        r.sda_pull = ~s.shift_byte[7];
        r.tick_count = 10'd1;
        r.phase = PH_WH;
      end
      PH_WH: begin r.scl_pull = 1'b0; r.tick_count = HIGH_CNT; r.phase = PH_WL; end
      PH_WL: begin
        r.scl_pull = 1'b1;
        r.shift_byte = {s.shift_byte[6:0], 1'b0};
        r.bit_index = bit_next;
        r.tick_count = 10'd1;
        r.phase = bit_next[3] ? PH_WA : PH_WB;
      end
      PH_WA: begin
        r.sda_pull = 1'b0;
        r.scl_pull = 1'b0;
        r.tick_count = 10'd1;
        r.phase = PH_WS;
      end
      PH_WS: begin
        if (sda_in) r.error_code = STATUS_NACK;
        r.scl_pull = 1'b1;
        r.tick_count = GAP_CNT;
        r.phase = PH_DONE;
      end
      PH_RC: begin
        r.sda_pull = 1'b0;
        r.scl_pull = 1'b0;
        r.stretch_left = (s.command_kind == OP_READ || s.byte_index == 2'd0) ?
                         s.limit_q : 8'd0;
        r.tick_count = 10'd1;
        r.phase = PH_RS;
      end
      PH_RS: begin
        if (scl_in) begin
          r.tick_count = SAMPLE_CNT;
          r.phase = PH_RP;
        end else if (s.stretch_left == 8'd0) begin
          r.error_code = STATUS_TIMEOUT;
          r.tick_count = SAMPLE_CNT;
          r.phase = PH_RP;
        end else begin
          r.stretch_left = s.stretch_left - 8'd1;
          r.tick_count = STRETCH_CNT;
          r.phase = PH_RS;
        end
      end
      PH_RP: begin
        r.shift_byte = {s.shift_byte[6:0], sda_in};
        r.scl_pull = 1'b1;
        r.bit_index = bit_next;
        r.tick_count = 10'd1;
        r.phase = bit_next[3] ? PH_RA : PH_RC;
      end
      PH_RA: begin
        if (s.command_kind == OP_READ_WORD && s.byte_index < 2'd2) r.sda_pull = 1'b1;
        else r.sda_pull = s.final_ack;
        r.tick_count = 10'd1;
        r.phase = PH_RH;
      end
      PH_RH: begin r.scl_pull = 1'b0; r.tick_count = HIGH_CNT; r.phase = PH_RE; end
      PH_RE: begin
        r.scl_pull = 1'b1;
        r.sda_pull = 1'b0;
        r.tick_count = GAP_CNT;
        r.phase = PH_RB;
      end
      PH_RB: begin
        // End of a received byte: finish a single read, collect a word byte, or check the CRC byte.
        r.tick_count = 10'd0;
        if (s.command_kind == OP_READ) begin
          r.phase = PH_DONE;
        end else if (s.byte_index == 2'd2) begin
          if (s.error_code == STATUS_OK && s.crc_value != s.shift_byte) begin
            r.error_code = STATUS_CRC;
          end
          r.phase = PH_DONE;
        end else begin
          if (s.byte_index == 2'd0) r.word_data = {s.shift_byte, 8'd0};
          else r.word_data = {s.word_data[15:8], s.shift_byte};
          r.crc_value = crc_update(s.crc_value, s.shift_byte);
          if (s.error_code != STATUS_OK) begin
            r.phase = PH_DONE;
          end else begin
            r.byte_index = s.byte_index + 2'd1;
            r.bit_index = 4'd0;
            r.phase = PH_RC;
          end
        end
      end
      PH_DONE: begin r.phase = PH_IDLE; r.tick_count = 10'd0; end
      default: begin r.phase = PH_IDLE; r.tick_count = 10'd0; end
    endcase
    return r;
  endfunction

  // Input register and its handshake.
  tick_t item_q;
  logic  item_q_valid;
  logic  fire;

  assign fire       = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (fire) begin
      item_q_valid <= 1'b0;
    end
    if (item_valid && item_ready) item_q <= item;
  end

  // Sequencer update for one tick, with up to three chained zero-length steps.
  seq_t    state;
  seq_t    st0;
  seq_t    st1;
  seq_t    st2;
  seq_t    state_next;
  result_t result_next;
  logic    done_now;

  always_comb begin
    st0 = state;
    if (state.phase == PH_IDLE) begin
      if (item_q.cmd_valid && item_q.opcode <= OP_READ_WORD) begin
        st0.command_kind = item_q.opcode;
        st0.error_code = STATUS_OK;
        st0.bit_index = 4'd0;
        st0.byte_index = 2'd0;
        st0.final_ack = item_q.send_ack;
        st0.limit_q = item_q.stretch_limit;
        st0.crc_value = CRC_INIT;
        st0.tick_count = 10'd0;
        case (item_q.opcode)
          OP_START: st0.phase = PH_S0;
          OP_STOP:  st0.phase = PH_P0;
          OP_WRITE: begin
            st0.shift_byte = item_q.tx_byte;
            st0.phase = PH_WB;
          end
          default: begin
            st0.shift_byte = 8'd0;
            st0.word_data = 16'd0;
            st0.phase = PH_RC;
          end
        endcase
      end
    end else begin
      st0.tick_count = state.tick_count - 10'd1;
    end

    st1 = (st0.phase != PH_IDLE && st0.tick_count == 10'd0) ?
          advance(st0, item_q.sda_sample, item_q.scl_sample) : st0;
    st2 = (st1.phase != PH_IDLE && st1.tick_count == 10'd0) ?
          advance(st1, item_q.sda_sample, item_q.scl_sample) : st1;
    state_next = (st2.phase != PH_IDLE && st2.tick_count == 10'd0) ?
                 advance(st2, item_q.sda_sample, item_q.scl_sample) : st2;

    // A command completes exactly when a running sequence falls back to idle.
    done_now = (state.phase != PH_IDLE) && (state_next.phase == PH_IDLE);

    result_next.scl_drive_low = state_next.scl_pull;
    result_next.sda_drive_low = state_next.sda_pull;
    result_next.busy_res      = state_next.phase != PH_IDLE;
    result_next.done_res      = done_now;
    result_next.read_data     = 16'd0;
    if (done_now) begin
      if (state_next.command_kind == OP_READ) begin
        result_next.read_data = {8'd0, state_next.shift_byte};
      end else if (state_next.command_kind == OP_READ_WORD) begin
        result_next.read_data = state_next.word_data;
      end
    end
    result_next.status = done_now ? state_next.error_code : STATUS_OK;
  end

  // Sequencer state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_RESET;
      result_valid <= 1'b0;
    end else if (fire) begin
      state <= state_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (fire) result <= result_next;
  end

`ifndef SYNTHESIS
  // The tick count runs exactly while a command is in progress.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_IDLE) == (state.tick_count == 10'd0))
    else $error("tick count out of step with sequencer phase");

  // A completing tick reports the command as no longer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_res |-> !result.busy_res)
    else $error("done result still marked busy");

  // Data and status are zero on every tick without completion.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.done_res |-> result.status == STATUS_OK &&
    result.read_data == 16'd0)
    else $error("status or data set without done");

  // A processed tick always lands in the result register.
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("processed tick produced no result word");
`endif

endmodule

`default_nettype wire
